### rtl/core/join_frame_checker_defines.svh
// Assertion macros used by the join frame checker RTL.
// No dependencies.
`ifndef JOIN_FRAME_CHECKER_DEFINES_SVH
`define JOIN_FRAME_CHECKER_DEFINES_SVH
// property must hold at every edge outside reset
`define JFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define JFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/core/jfc_pkg.sv
// Package for the join frame checker: payload types, constants, CRC step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jfc_pkg;
  localparam int unsigned SiteFieldBytes     = 32;
  localparam int unsigned IdentityFieldBytes = 16;
  localparam int unsigned HdrBytes           = 8;
  localparam int unsigned TrailerBytes       = 4;
  localparam int unsigned MinFrame           = HdrBytes + TrailerBytes;
  localparam int unsigned CountMax           = 127;
  localparam int unsigned ReqLen  = HdrBytes + 11 + SiteFieldBytes + IdentityFieldBytes
                                    + TrailerBytes;
  localparam int unsigned ChalLen = HdrBytes + 36 + TrailerBytes;
  localparam int unsigned RejLen  = HdrBytes + 4 + TrailerBytes;
  localparam logic [7:0]  LabEnv  = 8'd1;
  localparam logic [31:0] CrcPoly = 32'h82F63B78;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    REG_MAGIC   = 2'd0,
    REG_VERSION = 2'd1,
    REG_TYPE    = 2'd2,
    REG_KIND    = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_REQUEST   = 3'd0,
    KIND_CHALLENGE = 3'd1,
    KIND_RESPONSE  = 3'd2,
    KIND_INSTALL   = 3'd3,
    KIND_REJECT    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_STRUCT = 2'd1,
    ST_CRC  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] session_word;
    logic [63:0] epoch_value;
    logic [63:0] expiry_time;
    logic [31:0] reject_reason;
    logic [7:0]  env_byte;
    logic [7:0]  site_length;
    logic [7:0]  identity_length;
  } out_item_t;

  // byte classified by the front end, with the settings seen at that byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       hdr_mismatch;
    logic [2:0] kind;
    logic [6:0] pos;
  } class_item_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [6:0] kind_frame_bytes(logic [2:0] kind);
    logic [6:0] l;
    case (kind)
      KIND_REQUEST:                                l = 7'(ReqLen);
      KIND_CHALLENGE, KIND_RESPONSE, KIND_INSTALL: l = 7'(ChalLen);
      KIND_REJECT:                                 l = 7'(RejLen);
      default:                                     l = 7'd0;
    endcase
    return l;
  endfunction
endpackage
`default_nettype wire

### rtl/core/jfc_front.sv
// Front end: accepts bytes, tracks position, compares header bytes.
// Depends on jfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jfc_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire jfc_pkg::in_item_t  in_data_i,
  input  wire logic [31:0]        magic_i,
  input  wire logic [7:0]         version_i,
  input  wire logic [7:0]         type_i,
  input  wire logic [2:0]         kind_i,
  output logic                    q_valid_o,
  input  wire logic               q_full_i,
  output jfc_pkg::class_item_t    q_data_o
);
  import jfc_pkg::*;
  logic [6:0] pos_q, pos_d;
  logic       mis;
  logic       acc;

  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i && !q_full_i;
  assign q_valid_o  = acc;

  always_comb begin
    mis = 1'b0;
    case (pos_q)
      7'd0: mis = in_data_i.data_byte != magic_i[31:24];
      7'd1: mis = in_data_i.data_byte != magic_i[23:16];
      7'd2: mis = in_data_i.data_byte != magic_i[15:8];
      7'd3: mis = in_data_i.data_byte != magic_i[7:0];
      7'd4: mis = in_data_i.data_byte != version_i;
      7'd5: mis = in_data_i.data_byte != type_i;
      default: mis = 1'b0;
    endcase
  end

  assign q_data_o = '{data_byte: in_data_i.data_byte, last_byte: in_data_i.last_byte,
                      hdr_mismatch: mis, kind: kind_i, pos: pos_q};

  always_comb begin
    pos_d = pos_q;
    if (acc) begin
      if (in_data_i.last_byte) pos_d = 7'd0;
      else if (pos_q != 7'(CountMax)) pos_d = pos_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pos_q <= '0;
    else         pos_q <= pos_d;
  end
endmodule
`default_nettype wire

### rtl/core/jfc_queue.sv
// Short FIFO between front and back end.
// Depends on jfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jfc_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_i,
  input  wire jfc_pkg::class_item_t wdata_i,
  output logic                      full_o,
  output logic                      valid_o,
  input  wire logic                 rd_i,
  output jfc_pkg::class_item_t      rdata_o
);
  import jfc_pkg::*;
  localparam int unsigned AW = $clog2(QueueDepth);
  class_item_t       mem_q [QueueDepth];
  logic [AW-1:0]     wp_q, rp_q;
  logic [AW:0]       cnt_q;

  assign full_o  = cnt_q == (AW+1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + AW'(1);
      if (rd_i) rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(wr_i) - (AW+1)'(rd_i);
    end
  end
endmodule
`default_nettype wire

### rtl/core/jfc_back.sv
// Back end: CRC, body field decode, verdict, single output register.
// Depends on jfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jfc_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_valid_i,
  input  wire jfc_pkg::class_item_t q_data_i,
  output logic                      q_rd_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output jfc_pkg::out_item_t        out_data_o
);
  import jfc_pkg::*;
  logic [31:0] crc_q;
  logic [7:0]  td_q [4];
  logic        hbad_q, bbad_q, nz0_q, nz1_q;
  logic [15:0] decl_q;
  logic [63:0] wa_q, wb_q;
  logic [31:0] word_q;
  logic [7:0]  lb0_q, lb1_q, lb2_q;
  logic        ov_q;
  out_item_t   od_q, res;

  class_item_t it;
  logic        go, in_body;
  logic [6:0]  p, expect_len, r;
  logic [7:0]  b, pi;
  logic [31:0] crc_n, wire_crc;
  logic [63:0] wa_n, wb_n;
  logic [31:0] word_n;
  logic [7:0]  lb0_n, lb1_n, lb2_n;
  logic        bbad_n, nz0_n, nz1_n, hbad_n, fail;
  logic [15:0] decl_n;

  assign it = q_data_i;
  assign p  = it.pos;
  assign b  = it.data_byte;
  // only a final byte needs the output register free; other bytes always move on
  assign q_rd_o = q_valid_i && (!it.last_byte || !ov_q || !out_stall_i);
  assign go = q_rd_o;
  assign expect_len = kind_frame_bytes(it.kind);
  assign in_body = p >= 7'(HdrBytes) && p != 7'(CountMax) && expect_len >= 7'(MinFrame)
                   && p < expect_len - 7'(TrailerBytes);
  assign r = p - 7'(HdrBytes);

  always_comb begin
    hbad_n = hbad_q | it.hdr_mismatch;
    decl_n = decl_q;
    if (p == 7'd6 || p == 7'd7) decl_n = {decl_q[7:0], b};
    wa_n = wa_q; wb_n = wb_q; word_n = word_q;
    lb0_n = lb0_q; lb1_n = lb1_q; lb2_n = lb2_q;
    bbad_n = bbad_q; nz0_n = nz0_q; nz1_n = nz1_q;
    pi = 8'd0;
    if (in_body) begin
      case (it.kind)
        KIND_REQUEST: begin
          if (r < 7'd8) wa_n = {wa_q[55:0], b};
          else if (r == 7'd8) lb0_n = b;
          else if (r == 7'd9) lb1_n = b;
          else if (r < 7'(10 + SiteFieldBytes)) begin
            pi = 8'(r - 7'd10);
            if (b != 8'd0) begin
              if (pi < lb1_q) nz0_n = 1'b1; else bbad_n = 1'b1;
            end
          end else if (r == 7'(10 + SiteFieldBytes)) lb2_n = b;
          else if (r < 7'(11 + SiteFieldBytes + IdentityFieldBytes)) begin
            pi = 8'(r - 7'(11 + SiteFieldBytes));
            if (b != 8'd0) begin
              if (pi < lb2_q) nz1_n = 1'b1; else bbad_n = 1'b1;
            end
          end
        end
        KIND_CHALLENGE: begin
          if (r < 7'd16) begin if (b != 8'd0) nz0_n = 1'b1; end
          else if (r < 7'd24) wb_n = {wb_q[55:0], b};
          else if (r < 7'd32) wa_n = {wa_q[55:0], b};
          else if (r < 7'd36) word_n = {word_q[23:0], b};
        end
        KIND_RESPONSE, KIND_INSTALL: begin
          if (r < 7'd4) word_n = {word_q[23:0], b};
          else if (r < 7'd36) begin if (b != 8'd0) nz0_n = 1'b1; end
        end
        KIND_REJECT: if (r < 7'd4) word_n = {word_q[23:0], b};
        default: ;
      endcase
    end
    crc_n = (p >= 7'd4) ? crc_byte(crc_q, td_q[0]) : crc_q;
    wire_crc = {td_q[1], td_q[2], td_q[3], b};
  end

  always_comb begin
    fail = 1'b0;
    case (it.kind)
      KIND_REQUEST: fail = lb0_n != LabEnv || lb1_n == 8'd0
        || lb1_n > 8'(SiteFieldBytes) || !nz0_n || lb2_n == 8'd0
        || lb2_n > 8'(IdentityFieldBytes) || !nz1_n || wa_n == 64'd0 || bbad_n;
      KIND_CHALLENGE: fail = wa_n == 64'd0 || word_n == 32'd0 || !nz0_n;
      KIND_RESPONSE, KIND_INSTALL: fail = word_n == 32'd0 || !nz0_n;
      default: fail = 1'b0;
    endcase
    res = '0;
    // count after this byte is p+1 (p is saturated at CountMax)
    if (p < 7'(MinFrame - 1) || hbad_n || expect_len == 7'd0
        || decl_n != {9'd0, expect_len} || p + 7'd1 != expect_len) begin
      res.status = ST_STRUCT;
    end else if (wire_crc != ~crc_n) begin
      res.status = ST_CRC;
    end else begin
      res.status = fail ? ST_STRUCT : ST_OK;
      case (it.kind)
        KIND_REQUEST: begin
          res.epoch_value = wa_n;
          res.env_byte = lb0_n;
          res.site_length = lb1_n;
          res.identity_length = lb2_n;
        end
        KIND_CHALLENGE: begin
          res.session_word = word_n;
          res.epoch_value = wa_n;
          res.expiry_time = wb_n;
        end
        KIND_RESPONSE, KIND_INSTALL: res.session_word = word_n;
        KIND_REJECT: res.reject_reason = word_n;
        default: ;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  always_ff @(posedge clk_i) begin
    if (go && it.last_byte) od_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      crc_q <= '1; hbad_q <= 1'b0; bbad_q <= 1'b0; nz0_q <= 1'b0; nz1_q <= 1'b0;
      decl_q <= '0; wa_q <= '0; wb_q <= '0; word_q <= '0;
      lb0_q <= '0; lb1_q <= '0; lb2_q <= '0;
      for (int i = 0; i < 4; i++) td_q[i] <= '0;
    end else begin
      ov_q <= (ov_q && out_stall_i) || (go && it.last_byte);
      if (go) begin
        if (it.last_byte) begin
          crc_q <= '1; hbad_q <= 1'b0; bbad_q <= 1'b0; nz0_q <= 1'b0; nz1_q <= 1'b0;
          decl_q <= '0; wa_q <= '0; wb_q <= '0; word_q <= '0;
          lb0_q <= '0; lb1_q <= '0; lb2_q <= '0;
          for (int i = 0; i < 4; i++) td_q[i] <= '0;
        end else begin
          crc_q <= crc_n; hbad_q <= hbad_n; bbad_q <= bbad_n;
          nz0_q <= nz0_n; nz1_q <= nz1_n; decl_q <= decl_n;
          wa_q <= wa_n; wb_q <= wb_n; word_q <= word_n;
          lb0_q <= lb0_n; lb1_q <= lb1_n; lb2_q <= lb2_n;
          td_q[0] <= td_q[1]; td_q[1] <= td_q[2]; td_q[2] <= td_q[3]; td_q[3] <= b;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/join_frame_checker.sv
// Usage notes for join_frame_checker.
// Input channel in_valid_i/in_stall_o/in_data_i carries one frame byte per transfer
// with last_byte set on the final byte. Output channel out_valid_o/out_stall_i/
// out_data_o carries one verdict per frame, produced by the final byte.
// Throughput: one byte per cycle while in_stall_o is low, set by the byte-wise
// CRC-32C step and field checks in the back end; frames may follow each other with
// no gap. A byte enters the 4-entry queue in its transfer cycle and is consumed at
// the earliest on the next edge; out_valid_o is registered after the last byte
// leaves the queue, when the queue and the output register are free. When the
// receiver stalls, the held verdict stays in the output register; the back end
// keeps consuming non-final bytes, the next final byte waits at the head of the
// queue, and in_stall_o rises once the queue holds four entries. Reset clears the
// registers, the queue and all frame state. The user must write configuration via
// cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle; the block does not enforce it.
// Depends on jfc_pkg, jfc_front, jfc_queue, jfc_back and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "join_frame_checker_defines.svh"
module join_frame_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire jfc_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output jfc_pkg::out_item_t       out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [31:0]         cfg_wdata_i
);
  import jfc_pkg::*;
  logic [31:0] magic_q;
  logic [7:0]  ver_q, type_q;
  logic [2:0]  kind_q;
  logic        qw, qfull, qv, qrd;
  class_item_t qwd, qrdd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0; ver_q <= '0; type_q <= '0; kind_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MAGIC:   magic_q <= cfg_wdata_i;
        REG_VERSION: ver_q   <= cfg_wdata_i[7:0];
        REG_TYPE:    type_q  <= cfg_wdata_i[7:0];
        REG_KIND:    kind_q  <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  jfc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .magic_i(magic_q), .version_i(ver_q), .type_i(type_q), .kind_i(kind_q),
    .q_valid_o(qw), .q_full_i(qfull), .q_data_o(qwd)
  );

  jfc_queue u_queue (
    .clk_i, .rst_ni, .wr_i(qw), .wdata_i(qwd), .full_o(qfull),
    .valid_o(qv), .rd_i(qrd), .rdata_o(qrdd)
  );

  jfc_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_data_i(qrdd), .q_rd_o(qrd),
    .out_valid_o, .out_stall_i, .out_data_o
  );

  `JFC_ASSERT(a_no_read_empty, !qrd || qv, "queue read while empty")
  `JFC_ASSERT(a_status_range, !out_valid_o || out_data_o.status != 2'd3, "bad status code")
  `JFC_ASSERT_NEXT(a_hold_out, out_valid_o && out_stall_i, out_valid_o, "verdict dropped")
endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for join_frame_checker: frame bytes in, one verdict out per frame.
// Depends on jfc_pkg and the join_frame_checker RTL; the predictor is written locally.
`timescale 1ns / 1ps
module tb_top;
  import jfc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  join_frame_checker u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  // mirror of the block's settings and frame state
  logic [31:0] m_magic;
  logic [7:0]  m_version, m_type;
  logic [2:0]  m_kind;
  int unsigned f_idx;
  logic [31:0] f_crc;
  logic [7:0]  f_tail [4];
  logic        f_hdr_bad, f_body_bad;
  logic [15:0] f_decl;
  logic        f_nz [2];
  logic [63:0] f_wa, f_wb;
  logic [31:0] f_word;
  logic [7:0]  f_len [3];

  out_item_t verdict_q[$];
  // typed-in status for the directed frames, in verdict order
  logic      dir_chk[$];
  status_e   dir_st[$];
  int mismatches = 0;
  int idle_cycles = 0;
  logic hold_off = 1'b0;
  int unsigned cyc_mode = 0;

  function automatic int unsigned kind_len(logic [2:0] k);
    case (k)
      KIND_REQUEST: return 23 + SiteFieldBytes + IdentityFieldBytes;
      KIND_CHALLENGE, KIND_RESPONSE, KIND_INSTALL: return 48;
      KIND_REJECT: return 16;
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'h82F63B78) : (r >> 1);
    return r;
  endfunction

  function automatic void clear_frame();
    f_idx = 0; f_crc = '1; f_hdr_bad = 0; f_body_bad = 0; f_decl = 0;
    f_wa = 0; f_wb = 0; f_word = 0;
    for (int i = 0; i < 4; i++) f_tail[i] = 0;
    for (int i = 0; i < 3; i++) f_len[i] = 0;
    f_nz[0] = 0; f_nz[1] = 0;
  endfunction

  function automatic void padded(int unsigned i, logic [7:0] len, logic [7:0] b, int w);
    if (b != 0) begin
      if (i < len) f_nz[w] = 1; else f_body_bad = 1;
    end
  endfunction

  function automatic void body_byte(int unsigned r, logic [7:0] b);
    int unsigned s, d;
    s = SiteFieldBytes; d = IdentityFieldBytes;
    case (m_kind)
      KIND_REQUEST: begin
        if (r < 8) f_wa = {f_wa[55:0], b};
        else if (r == 8) f_len[0] = b;
        else if (r == 9) f_len[1] = b;
        else if (r < 10 + s) padded(r - 10, f_len[1], b, 0);
        else if (r == 10 + s) f_len[2] = b;
        else if (r < 11 + s + d) padded(r - 11 - s, f_len[2], b, 1);
      end
      KIND_CHALLENGE: begin
        if (r < 16) begin if (b != 0) f_nz[0] = 1; end
        else if (r < 24) f_wb = {f_wb[55:0], b};
        else if (r < 32) f_wa = {f_wa[55:0], b};
        else if (r < 36) f_word = {f_word[23:0], b};
      end
      KIND_RESPONSE, KIND_INSTALL: begin
        if (r < 4) f_word = {f_word[23:0], b};
        else if (r < 36) begin if (b != 0) f_nz[0] = 1; end
      end
      KIND_REJECT: if (r < 4) f_word = {f_word[23:0], b};
      default: ;
    endcase
  endfunction

  function automatic logic body_fails();
    case (m_kind)
      KIND_REQUEST: return f_len[0] != LabEnv || f_len[1] == 0 || f_len[1] > SiteFieldBytes
        || !f_nz[0] || f_len[2] == 0 || f_len[2] > IdentityFieldBytes || !f_nz[1]
        || f_wa == 0 || f_body_bad;
      KIND_CHALLENGE: return f_wa == 0 || f_word == 0 || !f_nz[0];
      KIND_RESPONSE, KIND_INSTALL: return f_word == 0 || !f_nz[0];
      default: return 1'b0;
    endcase
  endfunction

  // advance the predictor by one accepted byte; returns 1 with a verdict on the last byte
  function automatic logic predict_byte(in_item_t it, output out_item_t v);
    int unsigned p, exp_len;
    logic [31:0] wire_crc;
    logic [7:0] b;
    b = it.data_byte; p = f_idx; exp_len = kind_len(m_kind); v = '0;
    if (p < 4) begin
      if (b != m_magic[31 - 8*p -: 8]) f_hdr_bad = 1;
    end else if (p == 4) begin
      if (b != m_version) f_hdr_bad = 1;
    end else if (p == 5) begin
      if (b != m_type) f_hdr_bad = 1;
    end else if (p < 8) begin
      f_decl = {f_decl[7:0], b};
    end else if (p < 127 && exp_len >= 12 && p < exp_len - 4) begin
      body_byte(p - 8, b);
    end
    if (p >= 4) f_crc = crc_step(f_crc, f_tail[0]);
    f_tail[0] = f_tail[1]; f_tail[1] = f_tail[2]; f_tail[2] = f_tail[3]; f_tail[3] = b;
    if (f_idx < 127) f_idx++;
    if (!it.last_byte) return 1'b0;
    wire_crc = {f_tail[0], f_tail[1], f_tail[2], f_tail[3]};
    if (f_idx < 12 || f_hdr_bad || exp_len == 0 || f_decl != exp_len || f_idx != exp_len)
      v.status = ST_STRUCT;
    else if (wire_crc != ~f_crc)
      v.status = ST_CRC;
    else begin
      v.status = body_fails() ? ST_STRUCT : ST_OK;
      case (m_kind)
        KIND_REQUEST: begin
          v.epoch_value = f_wa; v.env_byte = f_len[0];
          v.site_length = f_len[1]; v.identity_length = f_len[2];
        end
        KIND_CHALLENGE: begin
          v.session_word = f_word; v.epoch_value = f_wa; v.expiry_time = f_wb;
        end
        KIND_RESPONSE, KIND_INSTALL: v.session_word = f_word;
        KIND_REJECT: v.reject_reason = f_word;
        default: ;
      endcase
    end
    clear_frame();
    return 1'b1;
  endfunction

  // predictor and scoreboard update on accepted transfers
  always @(posedge clk) begin
    out_item_t v, e;
    logic      dchk;
    status_e   dst;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (predict_byte(in_data, v)) verdict_q.push_back(v);
      end
      if (out_valid && !out_stall) begin
        if (dir_chk.size() != 0) begin
          dchk = dir_chk.pop_front();
          dst = dir_st.pop_front();
          if (dchk && out_data.status != dst) begin
            mismatches++;
            if (mismatches <= 10)
              $display("directed verdict: exp status %0d got %0d", dst, out_data.status);
          end
        end
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected verdict %p", out_data);
        end else begin
          e = verdict_q.pop_front();
          if (out_data !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("verdict mismatch: exp %p got %p", e, out_data);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: own stall pattern, with long hold-off on request
  always @(posedge clk) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (hold_off) out_stall <= 1'b1;
    else case ((cyc_mode / 300) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= (r < 30);
      default: out_stall <= (r < 75);
    endcase
  end
  always @(posedge clk) cyc_mode <= cyc_mode + 1;

  task automatic cfg_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAGIC: m_magic = val;
      REG_VERSION: m_version = val[7:0];
      REG_TYPE: m_type = val[7:0];
      default: m_kind = val[2:0];
    endcase
  endtask

  // stop offering and wait until every expected verdict has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  int burst_left = 0;
  // offer one byte, returning at its accepting edge with valid still high;
  // bursts with random gaps unless steady is set
  task automatic send_byte(logic [7:0] b, logic lst, logic steady);
    int unsigned gap;
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid <= 1'b1; in_data <= '{data_byte: b, last_byte: lst};
    do @(posedge clk); while (in_stall);
  endtask

  int n_sent = 0;

  // build a frame of the configured kind; mode 0 good, 1 random body, 2 broken
  task automatic send_frame(int mode, logic steady);
    logic [7:0] fr [$];
    logic [31:0] c;
    int unsigned len, sl, il;
    len = kind_len(m_kind);
    if (len == 0 || mode == 2) len = $urandom_range(1, 140);
    fr = {};
    fr.push_back(m_magic[31:24]); fr.push_back(m_magic[23:16]);
    fr.push_back(m_magic[15:8]); fr.push_back(m_magic[7:0]);
    fr.push_back(m_version); fr.push_back(m_type);
    fr.push_back(len[15:8]); fr.push_back(len[7:0]);
    sl = $urandom_range(1, SiteFieldBytes); il = $urandom_range(1, IdentityFieldBytes);
    for (int unsigned i = 8; i + 4 < len || (len < 12 && i < len); i++) begin
      int unsigned r;
      logic [7:0] b;
      r = i - 8; b = 8'($urandom);
      if (mode == 0 && m_kind == KIND_REQUEST) begin
        if (r == 8) b = LabEnv;
        else if (r == 9) b = 8'(sl);
        else if (r >= 10 && r < 10 + SiteFieldBytes) b = (r - 10 < sl) ? b : 8'd0;
        else if (r == 10 + SiteFieldBytes) b = 8'(il);
        else if (r > 10 + SiteFieldBytes) b = (r - 11 - SiteFieldBytes < il) ? b : 8'd0;
      end
      if (mode == 1 && $urandom_range(0, 3) == 0) b = 8'd0;
      fr.push_back(b);
    end
    if (len >= 12) begin
      c = '1;
      foreach (fr[i]) c = crc_step(c, fr[i]);
      c = ~c;
      if (mode == 2 && $urandom_range(0, 1)) c ^= 32'h1 << $urandom_range(0, 31);
      fr.push_back(c[31:24]); fr.push_back(c[23:16]); fr.push_back(c[15:8]);
      fr.push_back(c[7:0]);
    end
    if (mode == 2 && $urandom_range(0, 2) == 0)
      fr[$urandom_range(0, fr.size() - 1)] ^= 8'($urandom);
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1, steady);
    n_sent += fr.size();
  endtask

  typedef struct {
    logic [7:0] b;
    logic       lst;
    logic       chk;
    status_e    st;
  } step_t;

  initial begin
    step_t dir [$];
    m_magic = 0; m_version = 0; m_type = 0; m_kind = KIND_REQUEST;
    clear_frame();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // directed: after reset all settings zero; short, extreme and one-byte frames
    dir = '{
      '{8'h00, 1'b1, 1'b1, ST_STRUCT},
      '{8'hFF, 1'b1, 1'b1, ST_STRUCT},
      '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
      '{8'hAA, 1'b1, 1'b1, ST_STRUCT},
      '{8'h55, 1'b1, 1'b1, ST_STRUCT}
    };
    foreach (dir[i]) begin
      if (dir[i].lst) begin
        dir_chk.push_back(dir[i].chk);
        dir_st.push_back(dir[i].st);
      end
      send_byte(dir[i].b, dir[i].lst, 1'b1);
    end
    drain();
    // every kind at extreme settings, good and with random bodies, plus unknown kinds
    for (int k = 0; k < 8; k++) begin
      cfg_write(REG_KIND, k);
      cfg_write(REG_MAGIC, (k % 2) ? 32'hFFFF_FFFF : 32'h0);
      cfg_write(REG_VERSION, (k % 2) ? 32'hFF : 32'h00);
      cfg_write(REG_TYPE, (k % 2) ? 32'h00 : 32'hFF);
      send_frame(0, 1'b0);
      send_frame(1, 1'b0);
      drain();
    end
    // long receiver hold-off with the sender still pushing; the sender stays
    // blocked on a full queue until the hold-off ends
    cfg_write(REG_KIND, KIND_REJECT);
    hold_off <= 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
      repeat (3) send_frame(0, 1'b1);
    join
    drain();
    // random phases
    while (n_sent < 1850) begin
      cfg_write(REG_KIND, $urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                    : $urandom_range(0, 4));
      cfg_write(REG_MAGIC, $urandom);
      cfg_write(REG_VERSION, $urandom);
      cfg_write(REG_TYPE, $urandom);
      repeat ($urandom_range(3, 8)) begin
        int unsigned r;
        r = $urandom_range(0, 9);
        if (n_sent < 1850) send_frame(r < 6 ? 0 : (r < 8 ? 1 : 2), 1'b0);
      end
      drain();
    end
    drain();
    if (mismatches == 0 && verdict_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/jfc_pkg.sv
rtl/core/jfc_front.sv
rtl/core/jfc_queue.sv
rtl/core/jfc_back.sv
rtl/core/join_frame_checker.sv
tb/tb_top.sv
